// ----- rtl/core/adc_scale_and_ema_filter_defines.svh -----
// Assertion macros shared by the filter RTL.
`ifndef ADC_SCALE_AND_EMA_FILTER_DEFINES_SVH
`define ADC_SCALE_AND_EMA_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ADCF_ASSERT_IMP(name, clk_s, rst_s, lhs, rhs, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ADCF_ASSERT_NXT(name, clk_s, rst_s, lhs, rhs, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ----- rtl/core/adcf_pkg.sv -----
`default_nettype none

package adcf_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int FULL_SCALE_DEF = 4095;
  localparam int FRAME_SLOT_W   = 6;
  localparam int GAIN_W         = 24;
  localparam int ACC_W          = 32;
  localparam int PROD_W         = 56;

  localparam logic [15:0] EMPTY_MARK = 16'hFFFF;
  localparam logic [16:0] ALPHA_ONE  = 17'h10000;
  localparam logic [47:0] ROUND_HALF = 48'd32768;

  // Register reset values
  localparam logic [23:0] VOUT_GAIN_RST   = 24'd570778;
  localparam logic [23:0] VIN_GAIN_RST    = 24'd580944;
  localparam logic [23:0] IOUT_GAIN_RST   = 24'd95781;
  localparam logic [15:0] IOUT_OFFSET_RST = 16'hFFF8;
  localparam logic [16:0] ALPHA_RST       = 17'd13107;

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_VOUT_GAIN   = 3'd1,
    REG_VIN_GAIN    = 3'd2,
    REG_IOUT_GAIN   = 3'd3,
    REG_IOUT_OFFSET = 3'd4,
    REG_ALPHA       = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_NOT_RUNNING = 2'd1,
    ERR_NO_DATA     = 2'd2
  } err_t;

  typedef struct packed {
    logic [15:0]             sample_vout;
    logic [15:0]             sample_vin;
    logic [15:0]             sample_iout;
    logic [FRAME_SLOT_W-1:0] frame_slot;
  } frame_t;

  typedef struct packed {
    logic        valid_res;
    err_t        error_code;
    logic [15:0] vout_mv;
    logic [15:0] vin_mv;
    logic [15:0] iout_ma;
    logic [11:0] echo_vout;
    logic [11:0] echo_vin;
    logic [11:0] echo_iout;
    logic [31:0] frame_count;
  } result_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [23:0] data;
  } cfg_wr_t;

  // Microcode
  typedef logic [3:0] step_t;

  typedef enum logic [2:0] {
    OP_CHECK,
    OP_MUL_GAIN,
    OP_SCALE,
    OP_MUL_ALPHA,
    OP_UPDATE,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    CH_VOUT,
    CH_VIN,
    CH_IOUT
  } chan_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_ERROR,
    COND_UNPRIMED
  } cond_t;

  typedef struct packed {
    op_t   op;
    chan_t ch;
    cond_t cond;
    step_t target;
  } ctrl_t;

  localparam step_t STEP_FIRST = 4'd0;
  localparam step_t STEP_VIN   = 4'd5;
  localparam step_t STEP_IOUT  = 4'd9;
  localparam step_t STEP_DONE  = 4'd13;

  function automatic ctrl_t adcf_ucode(input step_t s);
    ctrl_t c;
    c = '{op: OP_DONE, ch: CH_VOUT, cond: COND_NONE, target: STEP_DONE};
    unique case (s)
      4'd0:  c = '{op: OP_CHECK,     ch: CH_VOUT, cond: COND_ERROR,    target: STEP_DONE};
      4'd1:  c = '{op: OP_MUL_GAIN,  ch: CH_VOUT, cond: COND_NONE,     target: STEP_DONE};
      4'd2:  c = '{op: OP_SCALE,     ch: CH_VOUT, cond: COND_UNPRIMED, target: STEP_VIN};
      4'd3:  c = '{op: OP_MUL_ALPHA, ch: CH_VOUT, cond: COND_NONE,     target: STEP_DONE};
      4'd4:  c = '{op: OP_UPDATE,    ch: CH_VOUT, cond: COND_NONE,     target: STEP_DONE};
      4'd5:  c = '{op: OP_MUL_GAIN,  ch: CH_VIN,  cond: COND_NONE,     target: STEP_DONE};
      4'd6:  c = '{op: OP_SCALE,     ch: CH_VIN,  cond: COND_UNPRIMED, target: STEP_IOUT};
      4'd7:  c = '{op: OP_MUL_ALPHA, ch: CH_VIN,  cond: COND_NONE,     target: STEP_DONE};
      4'd8:  c = '{op: OP_UPDATE,    ch: CH_VIN,  cond: COND_NONE,     target: STEP_DONE};
      4'd9:  c = '{op: OP_MUL_GAIN,  ch: CH_IOUT, cond: COND_NONE,     target: STEP_DONE};
      4'd10: c = '{op: OP_SCALE,     ch: CH_IOUT, cond: COND_UNPRIMED, target: STEP_DONE};
      4'd11: c = '{op: OP_MUL_ALPHA, ch: CH_IOUT, cond: COND_NONE,     target: STEP_DONE};
      4'd12: c = '{op: OP_UPDATE,    ch: CH_IOUT, cond: COND_NONE,     target: STEP_DONE};
      default: c = '{op: OP_DONE,    ch: CH_VOUT, cond: COND_NONE,     target: STEP_DONE};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/adcf_frame_if.sv -----
`default_nettype none

interface adcf_frame_if import adcf_pkg::*; ();
  logic   valid;
  logic   ready;
  frame_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/adcf_result_if.sv -----
`default_nettype none

interface adcf_result_if import adcf_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/adcf_cfg_if.sv -----
`default_nettype none

interface adcf_cfg_if import adcf_pkg::*; ();
  logic    valid;
  logic    ready;
  cfg_wr_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/adc_scale_and_ema_filter.sv -----
`default_nettype none
// Channel   Modport  Payload                                   Transaction
// frame     sink     three raw samples, buffer slot            valid & ready
// result    source   status, filtered values, echoes, count    valid & ready
// cfg       sink     register index, write data                valid & ready
//
// A good frame with primed filters runs a check step, then four microcode steps
// per channel on one shared 32x24 multiplier, before its result is loaded.
// The first good frame loads the filters and skips the filter steps; a rejected
// frame jumps to its result. The next frame is taken once the result is loaded.
// Reset (rst, synchronous) clears filters, slot tracking and the counter and
// loads register defaults. A stalled result holds the sequencer at its last step.

`include "adc_scale_and_ema_filter_defines.svh"

module adc_scale_and_ema_filter import adcf_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  adcf_frame_if.sink    frame,
  adcf_result_if.source result,
  adcf_cfg_if.sink      cfg
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CMP_W  = ((SLOT_W > FRAME_SLOT_W) ? SLOT_W : FRAME_SLOT_W) + 1;
  localparam logic [15:0]       FULL_SCALE_V = 16'(FULL_SCALE);
  localparam logic [CMP_W-1:0]  SLOT_LIMIT   = CMP_W'(SLOT_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_LAST    = SLOT_W'(SLOT_COUNT - 1);

  // Configuration registers
  logic              enable;
  logic [GAIN_W-1:0] vout_gain;
  logic [GAIN_W-1:0] vin_gain;
  logic [GAIN_W-1:0] iout_gain;
  logic [15:0]       iout_offset;
  logic [16:0]       alpha;

  // Filter and frame-tracking state
  logic [ACC_W-1:0]  vout_acc;
  logic [ACC_W-1:0]  vin_acc;
  logic [ACC_W-1:0]  iout_acc;
  logic              primed;
  logic              slot_seen;
  logic [SLOT_W-1:0] prior_slot;
  logic [31:0]       new_frames;

  // Sequencer and datapath registers
  logic              busy;
  step_t             step;
  err_t              err;
  logic [15:0]       smp_vout;
  logic [15:0]       smp_vin;
  logic [15:0]       smp_iout;
  logic [SLOT_W-1:0] slot;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  diff;
  logic              rising;
  logic              out_valid;
  result_t           res;

  // Combinational signals
  ctrl_t             ctrl;
  logic              accept;
  logic              can_emit;
  logic              emit;
  logic              cond_hit;
  logic [CMP_W-1:0]  slot_wide;
  logic [SLOT_W-1:0] slot_clamped;
  logic              bad_data;
  err_t              err_in;
  logic [15:0]       raw_sel;
  logic [GAIN_W-1:0] gain_sel;
  logic [ACC_W-1:0]  acc_sel;
  logic [16:0]       alpha_eff;
  logic [ACC_W-1:0]  mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic [41:0]       offset_term;
  logic [41:0]       scaled_sum;
  logic [ACC_W-1:0]  scaled;
  logic [47:0]       rounded;
  logic [ACC_W-1:0]  ema_step;
  logic [ACC_W-1:0]  acc_new;
  logic              frame_new;
  logic [31:0]       new_frames_next;

  assign frame.ready  = !busy && !rst;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = res;

  assign accept   = frame.valid && frame.ready;
  assign can_emit = !out_valid || result.ready;
  assign ctrl     = adcf_ucode(step);
  assign emit     = busy && (ctrl.op == OP_DONE) && can_emit;

  // Fold out-of-range slots onto the last slot.
  assign slot_wide    = CMP_W'(frame.data.frame_slot);
  assign slot_clamped = (slot_wide >= SLOT_LIMIT) ? SLOT_LAST : SLOT_W'(slot_wide);

  // Classify the incoming frame; not-running wins over bad data.
  always_comb begin
    bad_data = (frame.data.sample_vout == EMPTY_MARK) ||
               (frame.data.sample_vin == EMPTY_MARK) ||
               (frame.data.sample_iout == EMPTY_MARK) ||
               (frame.data.sample_vout > FULL_SCALE_V) ||
               (frame.data.sample_vin > FULL_SCALE_V) ||
               (frame.data.sample_iout > FULL_SCALE_V);
    if (!enable) begin
      err_in = ERR_NOT_RUNNING;
    end else if (bad_data) begin
      err_in = ERR_NO_DATA;
    end else begin
      err_in = ERR_NONE;
    end
  end

  // Route the channel that the current microcode step names.
  always_comb begin
    unique case (ctrl.ch)
      CH_VOUT: begin
        raw_sel  = smp_vout;
        gain_sel = vout_gain;
        acc_sel  = vout_acc;
      end
      CH_VIN: begin
        raw_sel  = smp_vin;
        gain_sel = vin_gain;
        acc_sel  = vin_acc;
      end
      CH_IOUT: begin
        raw_sel  = smp_iout;
        gain_sel = iout_gain;
        acc_sel  = iout_acc;
      end
      default: begin
        raw_sel  = smp_vout;
        gain_sel = vout_gain;
        acc_sel  = vout_acc;
      end
    endcase
  end

  // Shared multiplier operands: gain times raw, or alpha times distance.
  assign alpha_eff = (alpha[16] && (alpha[15:0] != 16'd0)) ? ALPHA_ONE : alpha;
  assign mul_a = (ctrl.op == OP_MUL_ALPHA) ? diff : ACC_W'(raw_sel);
  assign mul_b = (ctrl.op == OP_MUL_ALPHA) ? GAIN_W'(alpha_eff) : gain_sel;

  // Scale: add the iout offset in Q16 (iout only), clamp to the unsigned 32-bit range.
  always_comb begin
    offset_term = (ctrl.ch == CH_IOUT) ?
                  {{10{iout_offset[15]}}, iout_offset, 16'h0000} : 42'd0;
    scaled_sum  = {2'b00, prod[39:0]} + offset_term;
    if (scaled_sum[41]) begin
      scaled = '0;
    end else if (scaled_sum[40:32] != 9'd0) begin
      scaled = '1;
    end else begin
      scaled = scaled_sum[31:0];
    end
  end

  // Filter step: round alpha * distance half up, move the accumulator by it.
  assign rounded  = prod[47:0] + ROUND_HALF;
  assign ema_step = rounded[47:16];
  assign acc_new  = rising ? (acc_sel + ema_step) : (acc_sel - ema_step);

  // Conditional jump of the microcode.
  always_comb begin
    unique case (ctrl.cond)
      COND_NONE:     cond_hit = 1'b0;
      COND_ERROR:    cond_hit = (err != ERR_NONE);
      COND_UNPRIMED: cond_hit = !primed;
      default:       cond_hit = 1'b0;
    endcase
  end

  // Count a frame when it is the first good one or its slot moved.
  assign frame_new       = (err == ERR_NONE) && (!slot_seen || (slot != prior_slot));
  assign new_frames_next = new_frames + 32'(frame_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      vout_gain   <= VOUT_GAIN_RST;
      vin_gain    <= VIN_GAIN_RST;
      iout_gain   <= IOUT_GAIN_RST;
      iout_offset <= IOUT_OFFSET_RST;
      alpha       <= ALPHA_RST;
      vout_acc    <= '0;
      vin_acc     <= '0;
      iout_acc    <= '0;
      primed      <= 1'b0;
      slot_seen   <= 1'b0;
      prior_slot  <= '0;
      new_frames  <= '0;
      busy        <= 1'b0;
      step        <= STEP_FIRST;
      out_valid   <= 1'b0;
    end else begin
      // Register writes; unknown indexes drop.
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.data.index)
          REG_ENABLE:      enable      <= cfg.data.data[0];
          REG_VOUT_GAIN:   vout_gain   <= cfg.data.data;
          REG_VIN_GAIN:    vin_gain    <= cfg.data.data;
          REG_IOUT_GAIN:   iout_gain   <= cfg.data.data;
          REG_IOUT_OFFSET: iout_offset <= cfg.data.data[15:0];
          REG_ALPHA:       alpha       <= cfg.data.data[16:0];
          default: ;
        endcase
      end

      // Raise valid as a result loads; drop it once taken.
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        // Latch the frame and start the program.
        smp_vout <= frame.data.sample_vout;
        smp_vin  <= frame.data.sample_vin;
        smp_iout <= frame.data.sample_iout;
        slot     <= slot_clamped;
        err      <= err_in;
        busy     <= 1'b1;
        step     <= STEP_FIRST;
      end else if (busy) begin
        unique case (ctrl.op)
          OP_CHECK: begin
            step <= cond_hit ? ctrl.target : step + 4'd1;
          end
          OP_MUL_GAIN, OP_MUL_ALPHA: begin
            prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
            step <= step + 4'd1;
          end
          OP_SCALE: begin
            // Unprimed: load the filter and skip to the next channel (after iout, to the result).
            if (!primed) begin
              unique case (ctrl.ch)
                CH_VOUT: vout_acc <= scaled;
                CH_VIN:  vin_acc  <= scaled;
                CH_IOUT: iout_acc <= scaled;
                default: ;
              endcase
            end
            rising <= (scaled >= acc_sel);
            diff   <= (scaled >= acc_sel) ? (scaled - acc_sel) : (acc_sel - scaled);
            step   <= cond_hit ? ctrl.target : step + 4'd1;
          end
          OP_UPDATE: begin
            unique case (ctrl.ch)
              CH_VOUT: vout_acc <= acc_new;
              CH_VIN:  vin_acc  <= acc_new;
              CH_IOUT: iout_acc <= acc_new;
              default: ;
            endcase
            step <= step + 4'd1;
          end
          OP_DONE: begin
            // Hold here until the output register is free.
            if (can_emit) begin
              res.valid_res   <= (err == ERR_NONE);
              res.error_code  <= err;
              res.vout_mv     <= vout_acc[31:16];
              res.vin_mv      <= vin_acc[31:16];
              res.iout_ma     <= iout_acc[31:16];
              res.echo_vout   <= (err == ERR_NONE) ? smp_vout[11:0] : 12'd0;
              res.echo_vin    <= (err == ERR_NONE) ? smp_vin[11:0] : 12'd0;
              res.echo_iout   <= (err == ERR_NONE) ? smp_iout[11:0] : 12'd0;
              res.frame_count <= new_frames_next;
              busy            <= 1'b0;
              new_frames      <= new_frames_next;
              if (frame_new) begin
                prior_slot <= slot;
                slot_seen  <= 1'b1;
              end
              if (err == ERR_NONE) begin
                primed <= 1'b1;
              end
            end
          end
          default: begin
            step <= STEP_DONE;
          end
        endcase
      end
    end
  end

  `ADCF_ASSERT_NXT(a_accept_starts, clk, rst, accept, busy && (step == STEP_FIRST), "frame not started")
  `ADCF_ASSERT_NXT(a_primed_sticks, clk, rst, primed, primed, "primed flag cleared")
  `ADCF_ASSERT_IMP(a_count_on_good, clk, rst, !$stable(new_frames), $past(busy && (err == ERR_NONE)), "count moved on rejected frame")
  `ADCF_ASSERT_NXT(a_done_holds, clk, rst, busy && (step == STEP_DONE) && out_valid && !result.ready, busy && (step == STEP_DONE), "result overwritten while stalled")

endmodule

`default_nettype wire

// ----- dv/adc_scale_and_ema_filter_checker.sv -----
`timescale 1ns / 100ps

module adc_scale_and_ema_filter_checker import adcf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  adcf_frame_if  frame,
  adcf_result_if result,
  adcf_cfg_if    cfg,
  output int     fail_count,
  output int     pending_cnt
);

  // Shadow registers
  logic              run_en;
  logic [23:0]       gain_vout;
  logic [23:0]       gain_vin;
  logic [23:0]       gain_iout;
  logic signed [15:0] offset_iout;
  logic [16:0]       alpha_q16;

  // Filter and frame tracking state
  logic [31:0] acc_vout;
  logic [31:0] acc_vin;
  logic [31:0] acc_iout;
  logic        primed;
  logic        slot_valid;
  logic [5:0]  last_slot;
  logic [31:0] frames_seen;

  result_t pending_results[$];

  // Scale a raw count to Q16.16, add the offset in whole units, clamp to 32 bits.
  function automatic logic [31:0] scale_sample(input logic [15:0] raw,
                                               input logic [23:0] gain,
                                               input logic signed [15:0] offs);
    longint prod;
    prod = longint'(raw) * longint'(gain) + longint'(offs) * 64'sd65536;
    if (prod < 0) return 32'd0;
    if (prod > 64'sh0000_0000_FFFF_FFFF) return 32'hFFFF_FFFF;
    return prod[31:0];
  endfunction

  // Move acc toward x by alpha * |x - acc|, rounded half away from zero.
  function automatic logic [31:0] smooth(input logic [31:0] acc, input logic [31:0] x,
                                         input logic [16:0] a);
    longint unsigned diff;
    longint unsigned stp;
    if (x >= acc) begin
      diff = longint'(x - acc);
      stp  = (longint'(a) * diff + 64'd32768) >> 16;
      return acc + stp[31:0];
    end
    diff = longint'(acc - x);
    stp  = (longint'(a) * diff + 64'd32768) >> 16;
    return acc - stp[31:0];
  endfunction

  function automatic result_t filter_frame(input frame_t f);
    result_t     r;
    logic [16:0] a_eff;
    logic        bad;
    r = '0;
    r.error_code = ERR_NONE;
    bad = (f.sample_vout == EMPTY_MARK) || (f.sample_vin == EMPTY_MARK) ||
          (f.sample_iout == EMPTY_MARK) || (f.sample_vout > 16'(FULL_SCALE_DEF)) ||
          (f.sample_vin > 16'(FULL_SCALE_DEF)) || (f.sample_iout > 16'(FULL_SCALE_DEF));
    if (!run_en) begin
      r.error_code = ERR_NOT_RUNNING;
    end else if (bad) begin
      r.error_code = ERR_NO_DATA;
    end else begin
      a_eff = (alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : alpha_q16;
      if (!slot_valid || f.frame_slot != last_slot) begin
        frames_seen = frames_seen + 32'd1;
        last_slot   = f.frame_slot;
        slot_valid  = 1'b1;
      end
      if (!primed) begin
        acc_vout = scale_sample(f.sample_vout, gain_vout, 16'sd0);
        acc_vin  = scale_sample(f.sample_vin, gain_vin, 16'sd0);
        acc_iout = scale_sample(f.sample_iout, gain_iout, offset_iout);
        primed   = 1'b1;
      end else begin
        acc_vout = smooth(acc_vout, scale_sample(f.sample_vout, gain_vout, 16'sd0), a_eff);
        acc_vin  = smooth(acc_vin, scale_sample(f.sample_vin, gain_vin, 16'sd0), a_eff);
        acc_iout = smooth(acc_iout, scale_sample(f.sample_iout, gain_iout, offset_iout), a_eff);
      end
      r.valid_res = 1'b1;
      r.echo_vout = f.sample_vout[11:0];
      r.echo_vin  = f.sample_vin[11:0];
      r.echo_iout = f.sample_iout[11:0];
    end
    r.vout_mv     = acc_vout[31:16];
    r.vin_mv      = acc_vin[31:16];
    r.iout_ma     = acc_iout[31:16];
    r.frame_count = frames_seen;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      run_en      = 1'b0;
      gain_vout   = VOUT_GAIN_RST;
      gain_vin    = VIN_GAIN_RST;
      gain_iout   = IOUT_GAIN_RST;
      offset_iout = IOUT_OFFSET_RST;
      alpha_q16   = ALPHA_RST;
      acc_vout    = '0;
      acc_vin     = '0;
      acc_iout    = '0;
      primed      = 1'b0;
      slot_valid  = 1'b0;
      last_slot   = '0;
      frames_seen = '0;
      pending_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        got = result.data;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        end else begin
          want = pending_results.pop_front();
          check_field("valid_res", 32'(want.valid_res), 32'(got.valid_res));
          check_field("error_code", 32'(want.error_code), 32'(got.error_code));
          check_field("vout_mv", 32'(want.vout_mv), 32'(got.vout_mv));
          check_field("vin_mv", 32'(want.vin_mv), 32'(got.vin_mv));
          check_field("iout_ma", 32'(want.iout_ma), 32'(got.iout_ma));
          check_field("echo_vout", 32'(want.echo_vout), 32'(got.echo_vout));
          check_field("echo_vin", 32'(want.echo_vin), 32'(got.echo_vin));
          check_field("echo_iout", 32'(want.echo_iout), 32'(got.echo_iout));
          check_field("frame_count", want.frame_count, got.frame_count);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.index)
          REG_ENABLE:      run_en      = cfg.data.data[0];
          REG_VOUT_GAIN:   gain_vout   = cfg.data.data;
          REG_VIN_GAIN:    gain_vin    = cfg.data.data;
          REG_IOUT_GAIN:   gain_iout   = cfg.data.data;
          REG_IOUT_OFFSET: offset_iout = cfg.data.data[15:0];
          REG_ALPHA:       alpha_q16   = cfg.data.data[16:0];
          default: ;
        endcase
      end
      if (frame.valid && frame.ready) pending_results.push_back(filter_frame(frame.data));
    end
    pending_cnt = pending_results.size();
  end

endmodule

// ----- dv/adc_scale_and_ema_filter_tb.sv -----
`timescale 1ns / 100ps

module adc_scale_and_ema_filter_tb;
  import adcf_pkg::*;

  // Keep a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 10;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       rdy        = 1'b0;
  logic       no_idle    = 1'b0;
  logic [5:0] cur_slot   = '0;
  int         cycle_cnt  = 0;
  int         stall_left = 0;
  int         run_left   = 0;
  int         fail_count;
  int         pending_cnt;

  adcf_frame_if  frame_ch();
  adcf_result_if result_ch();
  adcf_cfg_if    cfg_ch();

  assign result_ch.ready = rdy;

  adc_scale_and_ema_filter u_dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Watch all three channels, predict each result and compare in order.
  adc_scale_and_ema_filter_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt)
  );

  always #1 clk = ~clk;

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result-side backpressure: stall bursts between ready runs (ready held high in
  // no_idle mode), some runs long enough to give stretches with no stalls at all.
  always @(negedge clk) begin
    if (no_idle) begin
      rdy <= 1'b1;
    end else if (stall_left != 0) begin
      rdy        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (run_left != 0) begin
      rdy      <= 1'b1;
      run_left <= run_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      rdy        <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      rdy      <= 1'b1;
      run_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(1, 30);
    end
  end

  function automatic frame_t mk_frame(input logic [15:0] v, input logic [15:0] i,
                                      input logic [15:0] c, input logic [5:0] s);
    frame_t f;
    f.sample_vout = v;
    f.sample_vin  = i;
    f.sample_iout = c;
    f.frame_slot  = s;
    return f;
  endfunction

  // In-range count, weighted toward the rails.
  function automatic logic [15:0] good_sample();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'(FULL_SCALE_DEF);
      default: return 16'($urandom_range(0, FULL_SCALE_DEF));
    endcase
  endfunction

  function automatic logic [15:0] bad_sample();
    if ($urandom_range(0, 1) == 0) return EMPTY_MARK;
    return 16'($urandom_range(FULL_SCALE_DEF + 1, 65534));
  endfunction

  // Mostly well-formed frames; the slot usually repeats or advances by one,
  // the way the DMA buffer fills, with occasional jumps.
  function automatic frame_t rand_frame();
    frame_t f;
    int     r;
    r = $urandom_range(0, 99);
    if (r >= 90)      cur_slot = 6'($urandom_range(0, 63));
    else if (r >= 70) cur_slot = cur_slot + 6'd1;
    f = mk_frame(good_sample(), good_sample(), good_sample(), cur_slot);
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 3))
        0: f.sample_vout = bad_sample();
        1: f.sample_vin  = bad_sample();
        2: f.sample_iout = bad_sample();
        default: begin
          f.sample_vout = bad_sample();
          f.sample_vin  = bad_sample();
          f.sample_iout = bad_sample();
        end
      endcase
    end
    return f;
  endfunction

  function automatic logic [23:0] rand_gain();
    if ($urandom_range(0, 3) == 0) return 24'($urandom_range(0, 24'hFF_FFFF));
    return 24'($urandom_range(40000, 800000));
  endfunction

  // Drive one frame transaction; called and returns just after a falling edge.
  task automatic send_frame(input frame_t f);
    frame_ch.data  = f;
    frame_ch.valid = 1'b1;
    do @(posedge clk); while (frame_ch.ready !== 1'b1);
    @(negedge clk);
    frame_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [23:0] value);
    cfg_ch.data.index = idx;
    cfg_ch.data.data  = value;
    cfg_ch.valid      = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Hold off until every outstanding result is back, then let the sequencer settle.
  task automatic drain_results();
    while (pending_cnt != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Program all registers for one phase: rails first, then disabled, then
  // power-on gains and offset with alpha at one, then random settings.
  task automatic set_phase(input int ph);
    logic        en;
    logic [23:0] gv;
    logic [23:0] gi;
    logic [23:0] gc;
    logic [15:0] offs;
    logic [16:0] a;
    en   = 1'b1;
    gv   = rand_gain();
    gi   = rand_gain();
    gc   = rand_gain();
    offs = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
    case ($urandom_range(0, 3))
      0:       a = 17'($urandom_range(0, 17'h1_FFFF));
      1:       a = ALPHA_ONE;
      default: a = 17'($urandom_range(1000, 30000));
    endcase
    case (ph)
      0: begin
        gv   = 24'hFF_FFFF;
        gi   = 24'hFF_FFFF;
        gc   = 24'hFF_FFFF;
        offs = 16'h7FFF;
        a    = 17'h1_FFFF;
      end
      1: begin
        gv   = 24'd0;
        gi   = 24'd0;
        gc   = 24'd0;
        offs = 16'h8000;
        a    = 17'd0;
      end
      2: en = 1'b0;
      3: begin
        gv   = VOUT_GAIN_RST;
        gi   = VIN_GAIN_RST;
        gc   = IOUT_GAIN_RST;
        offs = IOUT_OFFSET_RST;
        a    = ALPHA_ONE;
      end
      default: ;
    endcase
    write_reg(REG_ENABLE, 24'(en));
    write_reg(REG_VOUT_GAIN, gv);
    write_reg(REG_VIN_GAIN, gi);
    write_reg(REG_IOUT_GAIN, gc);
    write_reg(REG_IOUT_OFFSET, {8'h00, offs});
    write_reg(REG_ALPHA, {7'h00, a});
  endtask

  initial begin
    int gap_pct;
    int item_cnt;
    frame_ch.valid = 1'b0;
    frame_ch.data  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Disabled after reset: not-running error, even over bad data.
    send_frame(mk_frame(16'd100, 16'd200, 16'd300, 6'd0));
    send_frame(mk_frame(EMPTY_MARK, 16'd5000, 16'd0, 6'd1));
    drain_results();
    write_reg(REG_ENABLE, 24'd1);

    // Empty marker and out-of-range on each channel before the filters are primed.
    send_frame(mk_frame(EMPTY_MARK, 16'd10, 16'd10, 6'd0));
    send_frame(mk_frame(16'd10, EMPTY_MARK, 16'd10, 6'd0));
    send_frame(mk_frame(16'd10, 16'd10, EMPTY_MARK, 6'd0));
    send_frame(mk_frame(16'd4096, 16'd0, 16'd0, 6'd0));
    send_frame(mk_frame(16'd0, 16'd4096, 16'd0, 6'd0));
    send_frame(mk_frame(16'd0, 16'd0, 16'd4096, 6'd0));
    send_frame(mk_frame(16'hF000, 16'd0, 16'd0, 6'd0));

    // First good frame loads the filters; same slot leaves the count alone and
    // a zero current with negative offset clamps at zero.
    send_frame(mk_frame(16'd1000, 16'd2000, 16'd50, 6'd5));
    send_frame(mk_frame(16'd0, 16'd0, 16'd0, 6'd5));
    send_frame(mk_frame(16'd4095, 16'd4095, 16'd4095, 6'd63));
    // A rejected frame must not disturb slot tracking.
    send_frame(mk_frame(16'd4095, 16'd4095, EMPTY_MARK, 6'd10));
    send_frame(mk_frame(16'd4095, 16'd4095, 16'd4095, 6'd63));
    send_frame(mk_frame(16'd1, 16'd2, 16'd3, 6'd10));
    send_frame(mk_frame(16'd2048, 16'd1, 16'd4095, 6'd10));

    // Random phases, each under its own register setting. Registers only
    // change once the block has gone idle.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (ph == PHASES - 1) no_idle = 1'b1;
      set_phase(ph);
      item_cnt = (ph == 2) ? 40 : 150;
      case (ph % 3)
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 30;
      endcase
      if (no_idle) gap_pct = 0;
      for (int n = 0; n < item_cnt; n++) begin
        if ($urandom_range(0, 99) < gap_pct) repeat ($urandom_range(1, 18)) @(negedge clk);
        // Occasionally hold the sender until the pipeline is fully empty.
        if (!no_idle && (n == item_cnt / 2 || $urandom_range(0, 149) == 0)) drain_results();
        send_frame(rand_frame());
      end
    end

    while (pending_cnt != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
